>>> src/adw_pkg.sv
// Shared constants, beat types and the exponential clip table of the waveshaper.
// Used by every module of the block; depends on nothing.
package adw_pkg;

  localparam int SAMPLE_BITS       = 24;
  localparam int GAIN_BITS         = 24;
  localparam int GAIN_FRAC_BITS    = 16;
  localparam int MODE_BITS         = 3;
  localparam int CFG_INDEX_BITS    = 4;
  localparam int CFG_DATA_BITS     = 24;
  localparam int PROD_BITS         = SAMPLE_BITS + GAIN_BITS;
  localparam int M_BITS            = PROD_BITS - GAIN_FRAC_BITS;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_SPAN          = 16;
  localparam int EXP_V_BITS        = 31;
  localparam int LATENCY           = 9;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(65536);
  localparam logic [M_BITS-1:0]    FULL_M     = M_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [M_BITS-1:0]    HALF_M     = M_BITS'(1) << (SAMPLE_BITS - 2);
  localparam logic [EXP_V_BITS-1:0] EXP_ONE   = EXP_V_BITS'(1) << 30;
  localparam logic [63:0]          Q60_ONE    = 64'd1 << 60;
  localparam logic [63:0]          Q30_ONE    = 64'd1 << 30;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_HARD = 3'd0,
    MODE_SOFT = 3'd1,
    MODE_EXP  = 3'd2,
    MODE_FULL = 3'd3,
    MODE_HALF = 3'd4
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LINEAR_GAIN = 4'd0,
    REG_CURVE_MODE  = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [M_BITS-1:0] m;
  } gain_beat_t;

  typedef struct packed {
    logic              valid;
    logic              sneg;
    logic [M_BITS-1:0] mag;
  } mag_beat_t;

  typedef logic [EXP_V_BITS-1:0] exp_rom_t [EXP_TABLE_ENTRIES+1];

  // exp(-num/N) in Q30 from a Q60 Taylor series, N = EXP_TABLE_ENTRIES
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] num);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] negs;
    logic [63:0] v;
    term = Q60_ONE;
    pos  = Q60_ONE;
    negs = '0;
    for (int i = 1; i < 64; i++) begin
      term = (term / EXP_TABLE_ENTRIES) * num
           + ((term % EXP_TABLE_ENTRIES) * num) / EXP_TABLE_ENTRIES;
      term = term / 64'(i);
      if (i[0]) begin
        negs = negs + term;
      end else begin
        pos = pos + term;
      end
    end
    v = (pos > negs) ? pos - negs : 64'd0;
    return (v + (Q30_ONE >> 1)) >> 30;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] e1;
    logic [63:0] t;
    logic [63:0] ip;
    logic [63:0] r;
    logic [63:0] e;
    e1 = exp_neg_q30(64'(EXP_TABLE_ENTRIES));
    for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      t  = 64'(EXP_SPAN) * 64'(k);
      ip = t / EXP_TABLE_ENTRIES;
      r  = t % EXP_TABLE_ENTRIES;
      e  = exp_neg_q30(r);
      for (int j = 0; j < EXP_SPAN; j++) begin
        if (64'(j) < ip) begin
          e = (e * e1 + (Q30_ONE >> 1)) >> 30;
        end
      end
      rom[k] = (e < Q30_ONE) ? EXP_V_BITS'(Q30_ONE - e) : '0;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

>>> src/adw_gain.sv
// Gain front end: magnitude split, gain multiply and round half away from zero.
// Three register stages; uses adw_pkg.
module adw_gain
  import adw_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [GAIN_BITS-1:0]          gain,
  output gain_beat_t                    out_beat
);

  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_FRAC_BITS - 1);

  logic [SAMPLE_BITS-1:0] x_bits;
  logic                   s1_valid;
  logic                   s1_neg;
  logic [SAMPLE_BITS-1:0] s1_ax;
  logic                   s2_valid;
  logic                   s2_neg;
  logic [PROD_BITS-1:0]   s2_prod;
  logic [PROD_BITS-1:0]   rnd;

  assign x_bits = sample_in;
  assign rnd    = s2_prod + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      out_beat.valid <= 1'b0;
    end else begin
      s1_valid       <= in_valid;
      s2_valid       <= s1_valid;
      out_beat.valid <= s2_valid;
    end
    s1_neg     <= x_bits[SAMPLE_BITS-1];
    s1_ax      <= x_bits[SAMPLE_BITS-1] ? (~x_bits + SAMPLE_BITS'(1)) : x_bits;
    s2_neg     <= s1_neg;
    s2_prod    <= PROD_BITS'(s1_ax) * PROD_BITS'(gain);
    out_beat.neg <= s2_neg;
    out_beat.m   <= rnd[PROD_BITS-1:GAIN_FRAC_BITS];
  end

endmodule

>>> src/adw_shape.sv
// Curve stages: hard clip, piecewise soft clip, table exponential clip and rectifiers.
// Five register stages; uses adw_pkg and its EXP_ROM table.
module adw_shape
  import adw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [MODE_BITS-1:0] mode,
  input  gain_beat_t           in_beat,
  output mag_beat_t            out_beat
);

  localparam int SB         = SAMPLE_BITS;
  localparam int TM_BITS    = M_BITS + 2;
  localparam int LOG_N      = $clog2(EXP_TABLE_ENTRIES);
  localparam int LOG_SPAN   = $clog2(EXP_SPAN);
  localparam int SEG_SHIFT  = SB - 1 + LOG_SPAN - LOG_N;
  localparam int FRAC_BITS  = 16;
  localparam int DSQ_BITS   = 2 * (SB - 1);
  localparam int N_BITS     = 2 * SB;
  localparam int EPROD_BITS = EXP_V_BITS + FRAC_BITS;
  localparam int VF_BITS    = EXP_V_BITS + SB - 1;

  localparam logic [TM_BITS-1:0]    FULL_TM     = TM_BITS'(FULL_M);
  localparam logic [TM_BITS-1:0]    TWO_FULL_TM = FULL_TM << 1;
  localparam logic [N_BITS-1:0]     FULL_N      = N_BITS'(1) << (SB - 1);
  localparam logic [N_BITS-1:0]     KNEE_K      = N_BITS'(3 * FULL_N * FULL_N + 3 * FULL_N);
  localparam logic [31:0]           RECIP3      = 32'hAAAA_AAAB;
  localparam logic [EPROD_BITS-1:0] EPROD_RND   = EPROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [VF_BITS-1:0]    VF_RND      = VF_BITS'(1) << 29;
  localparam logic [M_BITS-1:0]     SEG_LIMIT   = M_BITS'(EXP_TABLE_ENTRIES);

  typedef enum logic [1:0] {
    SOFT_LINEAR = 2'd0,
    SOFT_KNEE   = 2'd1,
    SOFT_TOP    = 2'd2
  } soft_region_t;

  // stage 4 inputs
  logic [TM_BITS-1:0]             tm;
  logic [TM_BITS-1:0]             d_w;
  soft_region_t                   region;
  logic [M_BITS-1:0]              seg;
  logic [LOG_N:0]                 lo_idx;
  logic [LOG_N:0]                 hi_idx;
  logic [EXP_V_BITS-1:0]          rom_lo;
  logic [EXP_V_BITS-1:0]          rom_hi;
  logic [SEG_SHIFT+FRAC_BITS-1:0] fr_w;

  logic                  s4_valid;
  logic                  s4_neg;
  logic [M_BITS-1:0]     s4_m;
  soft_region_t          s4_region;
  logic [SB-2:0]         s4_d;
  logic [EXP_V_BITS-1:0] s4_lo;
  logic [EXP_V_BITS-1:0] s4_diff;
  logic [FRAC_BITS-1:0]  s4_frac;
  logic                  s4_beyond;

  logic                  s5_valid;
  logic                  s5_neg;
  logic [M_BITS-1:0]     s5_m;
  soft_region_t          s5_region;
  logic [DSQ_BITS-1:0]   s5_dsq;
  logic [EXP_V_BITS-1:0] s5_lo;
  logic [EPROD_BITS-1:0] s5_eprod;
  logic                  s5_beyond;

  logic [N_BITS-1:0]     knee_n;
  logic [EPROD_BITS-1:0] eprod_r;
  logic                  s6_valid;
  logic                  s6_neg;
  logic [M_BITS-1:0]     s6_m;
  soft_region_t          s6_region;
  logic [SB-1:0]         s6_q;
  logic [EXP_V_BITS-1:0] s6_v;

  logic                  s7_valid;
  logic                  s7_neg;
  logic [M_BITS-1:0]     s7_m;
  soft_region_t          s7_region;
  logic [63:0]           s7_qprod;
  logic [EXP_V_BITS-1:0] s7_v;

  logic [VF_BITS-1:0]    vf;
  logic [M_BITS-1:0]     knee_mag;
  logic [M_BITS-1:0]     exp_mag;
  logic [M_BITS-1:0]     mag_next;
  logic                  sneg_next;

  // stage 4: soft clip region and exp table lookup
  always_comb begin
    tm = (TM_BITS'(in_beat.m) << 1) + TM_BITS'(in_beat.m);
    d_w = TWO_FULL_TM - tm;
    if (tm > TWO_FULL_TM) begin
      region = SOFT_TOP;
    end else if (tm > FULL_TM) begin
      region = SOFT_KNEE;
    end else begin
      region = SOFT_LINEAR;
    end
    seg    = in_beat.m >> SEG_SHIFT;
    lo_idx = {1'b0, seg[LOG_N-1:0]};
    hi_idx = lo_idx + (LOG_N+1)'(1);
    rom_lo = EXP_ROM[lo_idx];
    rom_hi = EXP_ROM[hi_idx];
    fr_w   = {in_beat.m[SEG_SHIFT-1:0], {FRAC_BITS{1'b0}}} >> SEG_SHIFT;
  end

  // stage 6 inputs
  assign knee_n  = KNEE_K - N_BITS'(s5_dsq);
  assign eprod_r = s5_eprod + EPROD_RND;

  // stage 8: pick the curve
  always_comb begin
    vf       = {s7_v, {(SB-1){1'b0}}} + VF_RND;
    knee_mag = M_BITS'(s7_qprod[63:33]);
    exp_mag  = M_BITS'(vf[VF_BITS-1:30]);
    mag_next  = s7_m;
    sneg_next = s7_neg;
    case (mode)
      MODE_HARD: begin
        mag_next = (s7_m > HALF_M) ? HALF_M : s7_m;
      end
      MODE_SOFT: begin
        case (s7_region)
          SOFT_TOP:  mag_next = HALF_M;
          SOFT_KNEE: mag_next = knee_mag;
          default:   mag_next = s7_m;
        endcase
      end
      MODE_EXP: begin
        mag_next = exp_mag;
      end
      MODE_FULL: begin
        sneg_next = 1'b0;
      end
      MODE_HALF: begin
        mag_next  = s7_neg ? '0 : s7_m;
        sneg_next = 1'b0;
      end
      default: begin
        mag_next = s7_m;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid       <= 1'b0;
      s5_valid       <= 1'b0;
      s6_valid       <= 1'b0;
      s7_valid       <= 1'b0;
      out_beat.valid <= 1'b0;
    end else begin
      s4_valid       <= in_beat.valid;
      s5_valid       <= s4_valid;
      s6_valid       <= s5_valid;
      s7_valid       <= s6_valid;
      out_beat.valid <= s7_valid;
    end

    s4_neg    <= in_beat.neg;
    s4_m      <= in_beat.m;
    s4_region <= region;
    s4_d      <= d_w[SB-2:0];
    s4_lo     <= rom_lo;
    s4_diff   <= (rom_hi > rom_lo) ? rom_hi - rom_lo : '0;
    s4_frac   <= fr_w[FRAC_BITS-1:0];
    s4_beyond <= (seg >= SEG_LIMIT);

    s5_neg    <= s4_neg;
    s5_m      <= s4_m;
    s5_region <= s4_region;
    s5_dsq    <= DSQ_BITS'(s4_d) * DSQ_BITS'(s4_d);
    s5_lo     <= s4_lo;
    s5_eprod  <= EPROD_BITS'(s4_diff) * EPROD_BITS'(s4_frac);
    s5_beyond <= s4_beyond;

    s6_neg    <= s5_neg;
    s6_m      <= s5_m;
    s6_region <= s5_region;
    s6_q      <= knee_n[N_BITS-1:SB];
    s6_v      <= s5_beyond ? EXP_ONE : s5_lo + eprod_r[EPROD_BITS-1:FRAC_BITS];

    s7_neg    <= s6_neg;
    s7_m      <= s6_m;
    s7_region <= s6_region;
    s7_qprod  <= 64'(s6_q) * 64'(RECIP3);
    s7_v      <= s6_v;

    out_beat.sneg <= sneg_next;
    out_beat.mag  <= mag_next;
  end

  a_exp_bound: assert property (@(posedge clk) disable iff (rst)
    s6_valid |-> s6_v <= EXP_ONE)
    else $error("exp curve level above full scale");

  a_knee_bound: assert property (@(posedge clk) disable iff (rst)
    s7_valid && s7_region == SOFT_KNEE |-> s7_qprod[63:33] <= 31'(HALF_M))
    else $error("soft clip knee above half scale");

endmodule

>>> src/adw_out.sv
// Output stage: range limit, sign restore and the result register with its strobe.
// One register stage; uses adw_pkg.
module adw_out
  import adw_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  mag_beat_t                     in_beat,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          saturated
);

  localparam logic [SAMPLE_BITS-1:0] SAT_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [M_BITS-1:0] limit;
  logic              sat_next;
  logic [M_BITS-1:0] lim_mag;
  logic [M_BITS-1:0] signed_mag;

  always_comb begin
    limit      = in_beat.sneg ? FULL_M : FULL_M - M_BITS'(1);
    sat_next   = in_beat.mag > limit;
    lim_mag    = sat_next ? limit : in_beat.mag;
    signed_mag = in_beat.sneg ? (~lim_mag + M_BITS'(1)) : lim_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    sample_out <= signed_mag[SAMPLE_BITS-1:0];
    saturated  <= sat_next;
  end

  a_sat_level: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> sample_out == SAT_POS || sample_out == SAT_NEG)
    else $error("saturated beat not at a range limit");

endmodule

>>> src/audio_distortion_waveshaper.sv
// Waveshaper top level: configuration registers and the gain, curve and output pipeline.
// Instantiates adw_gain, adw_shape and adw_out; uses adw_pkg.
//
// Accepts one sample per clock: busy stays low, so every cycle with start high takes a beat.
// Each result leaves on sample_out and saturated with done high for one cycle, once its
// sample has passed the nine register stages; the stages are set by the gain multiplier,
// the soft clip square and reciprocal multipliers and the exp table interpolation. The
// receiver cannot stall, so nothing is ever held back. cfg_ready is always high; write
// linear_gain (index 0) and curve_mode (index 1) only when no result is still in flight.
// Curve modes 5 to 7 pass the gained sample through, limited to the output range.
module audio_distortion_waveshaper
  import adw_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  logic [GAIN_BITS-1:0] linear_gain;
  logic [MODE_BITS-1:0] curve_mode;
  gain_beat_t           gain_beat;
  mag_beat_t            mag_beat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain <= GAIN_RESET;
      curve_mode  <= MODE_HARD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINEAR_GAIN: linear_gain <= cfg_data[GAIN_BITS-1:0];
        REG_CURVE_MODE:  curve_mode  <= cfg_data[MODE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  adw_gain u_gain (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .sample_in(sample_in),
    .gain     (linear_gain),
    .out_beat (gain_beat)
  );

  adw_shape u_shape (
    .clk     (clk),
    .rst     (rst),
    .mode    (curve_mode),
    .in_beat (gain_beat),
    .out_beat(mag_beat)
  );

  adw_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (mag_beat),
    .done      (done),
    .sample_out(sample_out),
    .saturated (saturated)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result beat without a sample taken nine cycles earlier");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for audio_distortion_waveshaper: drives sample beats and
// register writes, predicts every curve, compares each result. Depends on adw_pkg.
`timescale 1ns / 100ps

module tb_top;
  import adw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [23:0] UNITY_GAIN = 24'd65536;
  localparam logic [23:0] MAX_GAIN = 24'hFFFFFF;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 4'd15;
  localparam logic [MODE_BITS-1:0] MODE_PASS_HI = 3'd7;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] FULL = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] THIRD = 24'd2796202;
  localparam logic [SAMPLE_BITS-1:0] TWO_THIRDS = 24'd5592405;

  typedef enum logic [1:0] {STIM_SAMPLE, STIM_WRITE, STIM_SETTLE} stim_kind_t;

  typedef struct {
    stim_kind_t                kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [SAMPLE_BITS-1:0]    smp;
    int                        gap;
  } stim_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   saturated;
  } shaped_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [SAMPLE_BITS-1:0]        sample_in = '0;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

  audio_distortion_waveshaper dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .done       (done),
    .sample_out (sample_out),
    .saturated  (saturated),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  stim_t   pending[$];
  shaped_t shaped_due[$];
  bit [63:0] exp_clip_rom [0:EXP_TABLE_ENTRIES];
  logic [23:0] gain_reg = UNITY_GAIN;
  logic [MODE_BITS-1:0] mode_reg = MODE_HARD;
  bit   took_sample = 0;
  bit   took_write = 0;
  int   gap_cnt = 0;
  int   settle_cnt = 0;
  int   idle_pct = 0;
  int   errors = 0;
  int   n_checked = 0;
  int   n_writes = 0;
  int   cycle_cnt = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // exp(-num/den) in Q30, Taylor series summed in Q60 with truncating steps
  function automatic bit [63:0] exp_series_q30(bit [63:0] num, bit [63:0] den);
    bit [63:0] term, up, down, v;
    term = 64'd1 << 60;
    up   = term;
    down = 0;
    for (int i = 1; i < 64; i++) begin
      term = (term / den) * num + ((term % den) * num) / den;
      term = term / 64'(i);
      if (i % 2 == 1) begin
        down += term;
      end else begin
        up += term;
      end
    end
    v = (up > down) ? up - down : 64'd0;
    return (v + (ONE_Q30 >> 1)) >> 30;
  endfunction

  function automatic shaped_t shape_sample(logic [SAMPLE_BITS-1:0] x);
    bit [63:0] ax, m, mag, lim, d, pos, span, seg, rem, frac, lo, hi, diff, v;
    bit neg, sneg;
    shaped_t r;
    neg  = x[SAMPLE_BITS-1];
    ax   = neg ? (64'd1 << SAMPLE_BITS) - 64'(x) : 64'(x);
    m    = (ax * 64'(gain_reg) + 64'h8000) >> 16;
    sneg = neg;
    case (mode_reg)
      MODE_HARD: mag = (m > FULL / 2) ? FULL / 2 : m;
      MODE_SOFT: begin
        if (3 * m > 2 * FULL) begin
          mag = FULL / 2;
        end else if (3 * m > FULL) begin
          d   = 2 * FULL - 3 * m;
          mag = (3 * FULL * FULL - d * d + 3 * FULL) / (6 * FULL);
        end else begin
          mag = m;
        end
      end
      MODE_EXP: begin
        span = 64'(EXP_SPAN) * FULL;
        pos  = m * 64'(EXP_TABLE_ENTRIES);
        seg  = pos / span;
        if (seg >= 64'(EXP_TABLE_ENTRIES)) begin
          v = ONE_Q30;
        end else begin
          rem  = pos - seg * span;
          frac = (rem << 16) / span;
          lo   = exp_clip_rom[seg];
          hi   = exp_clip_rom[seg + 1];
          diff = (hi > lo) ? hi - lo : 64'd0;
          v    = lo + ((diff * frac + 64'h8000) >> 16);
        end
        mag = (v * FULL + (ONE_Q30 >> 1)) >> 30;
      end
      MODE_FULL: begin
        mag  = m;
        sneg = 1'b0;
      end
      MODE_HALF: begin
        mag  = neg ? 64'd0 : m;
        sneg = 1'b0;
      end
      default: mag = m;
    endcase
    lim = sneg ? FULL : FULL - 1;
    r.saturated = (mag > lim);
    if (mag > lim) begin
      mag = lim;
    end
    r.sample_out = sneg ? SAMPLE_BITS'((64'd1 << SAMPLE_BITS) - mag) : SAMPLE_BITS'(mag);
    return r;
  endfunction

  function automatic int pick_gap();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      return $urandom_range(1, 15);
    end
    return 0;
  endfunction

  task automatic add_sample(logic [SAMPLE_BITS-1:0] s);
    stim_t e;
    e.kind = STIM_SAMPLE;
    e.idx  = '0;
    e.data = '0;
    e.smp  = s;
    e.gap  = pick_gap();
    pending.push_back(e);
  endtask

  task automatic add_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    stim_t e;
    e.kind = STIM_WRITE;
    e.idx  = idx;
    e.data = data;
    e.smp  = '0;
    e.gap  = pick_gap();
    pending.push_back(e);
  endtask

  task automatic add_settle();
    stim_t e;
    e.kind = STIM_SETTLE;
    e.idx  = '0;
    e.data = '0;
    e.smp  = '0;
    e.gap  = 0;
    pending.push_back(e);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] mode_word(logic [MODE_BITS-1:0] mode);
    return (CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'(7)) | CFG_DATA_BITS'(mode);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    logic [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: s = 24'h800000;
          1: s = 24'h7FFFFF;
          2: s = 24'h000000;
          3: s = 24'hFFFFFF;
          default: s = 24'h000001;
        endcase
      end
      1, 2: s = SAMPLE_BITS'($urandom_range(0, 1023));
      3: begin
        case ($urandom_range(0, 2))
          0: s = THIRD;
          1: s = TWO_THIRDS;
          default: s = SAMPLE_BITS'(FULL / 2);
        endcase
        s = s + SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
      end
      default: s = SAMPLE_BITS'($urandom);
    endcase
    if ($urandom_range(0, 1) == 1 && s != 24'h800000) begin
      s = -s;
    end
    return s;
  endfunction

  initial begin : stimulus
    bit [63:0] e1, t, whole, part, e;
    logic [CFG_DATA_BITS-1:0] g;
    int phase;

    e1 = exp_series_q30(64'(EXP_TABLE_ENTRIES), 64'(EXP_TABLE_ENTRIES));
    for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      t     = 64'(EXP_SPAN) * 64'(k);
      whole = t / EXP_TABLE_ENTRIES;
      part  = t % EXP_TABLE_ENTRIES;
      e     = exp_series_q30(part, 64'(EXP_TABLE_ENTRIES));
      for (bit [63:0] j = 0; j < whole; j++) begin
        e = (e * e1 + (ONE_Q30 >> 1)) >> 30;
      end
      exp_clip_rom[k] = (e < ONE_Q30) ? ONE_Q30 - e : 64'd0;
    end

    // reset settings: unity gain, hard clip
    add_sample(24'h7FFFFF);
    add_sample(24'h800000);
    add_sample(24'h000000);
    add_sample(24'hFFFFFF);
    add_settle();
    add_write(REG_CURVE_MODE, mode_word(MODE_SOFT));
    add_sample(THIRD);
    add_sample(SAMPLE_BITS'(THIRD + 1));
    add_sample(TWO_THIRDS);
    add_sample(SAMPLE_BITS'(TWO_THIRDS + 1));
    add_sample(SAMPLE_BITS'(-(TWO_THIRDS + 1)));
    add_settle();
    add_write(REG_CURVE_MODE, mode_word(MODE_EXP));
    add_write(REG_LINEAR_GAIN, MAX_GAIN);
    add_sample(24'h7FFFFF);
    add_sample(24'h800000);
    add_sample(24'h000001);
    add_settle();
    add_write(REG_LINEAR_GAIN, UNITY_GAIN);
    add_write(REG_CURVE_MODE, mode_word(MODE_FULL));
    add_sample(24'h800000);
    add_sample(24'h7FFFFF);
    add_settle();
    add_write(REG_CURVE_MODE, mode_word(MODE_HALF));
    add_write(REG_SPARE_LO, 24'hFFFFFF);
    add_sample(24'h800000);
    add_sample(24'h7FFFFF);
    add_settle();
    add_write(REG_CURVE_MODE, mode_word(MODE_PASS_HI));
    add_write(REG_LINEAR_GAIN, 24'd131072);
    add_write(REG_SPARE_HI, 24'h000000);
    add_sample(24'h7FFFFF);
    add_sample(24'h800000);
    add_sample(24'hC00000);
    add_settle();
    add_write(REG_CURVE_MODE, mode_word(MODE_HARD));
    add_write(REG_LINEAR_GAIN, 24'd0);
    add_sample(24'hFFFFFB);
    add_sample(24'h7FFFFF);

    for (phase = 0; phase < 16; phase++) begin
      idle_pct = (phase >= 14) ? 0 : (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 20 : 60;
      add_settle();
      case ($urandom_range(0, 5))
        0: g = UNITY_GAIN;
        1: g = MAX_GAIN;
        2: g = 24'd0;
        3: g = CFG_DATA_BITS'($urandom_range(16384, 262144));
        4: g = CFG_DATA_BITS'($urandom);
        default: g = CFG_DATA_BITS'($urandom_range(262144, 1048576));
      endcase
      add_write(REG_LINEAR_GAIN, g);
      add_write(REG_CURVE_MODE, mode_word(MODE_BITS'(phase % 8)));
      if ($urandom_range(0, 3) == 0) begin
        add_write(CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_DATA_BITS'($urandom));
      end
      repeat (106) add_sample(random_sample());
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start || cfg_valid) @(negedge clk);
    while (shaped_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    $display("Checked %0d shaped samples across %0d register writes, all curve modes,",
             n_checked, n_writes);
    $display("gain extremes and saturation cases; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("audio_distortion_waveshaper test passed");
    end else begin
      $display("audio_distortion_waveshaper test failed");
    end
    $finish;
  end

  always @(negedge clk) begin : drive
    stim_t head;
    logic nx_start, nx_cfg_valid;
    logic [SAMPLE_BITS-1:0] nx_sample;
    logic [CFG_INDEX_BITS-1:0] nx_index;
    logic [CFG_DATA_BITS-1:0] nx_data;
    nx_start     = start;
    nx_cfg_valid = cfg_valid;
    nx_sample    = sample_in;
    nx_index     = cfg_index;
    nx_data      = cfg_data;
    if (!rst && !((start && !took_sample) || (cfg_valid && !took_write))) begin
      nx_start     = 1'b0;
      nx_cfg_valid = 1'b0;
      if (pending.size() != 0) begin
        head = pending[0];
        if (gap_cnt < head.gap) begin
          gap_cnt++;
        end else if (head.kind == STIM_SETTLE) begin
          // hold until every result is back, then let the pipeline empty
          if (shaped_due.size() != 0) begin
            settle_cnt = 0;
          end else if (settle_cnt < LATENCY + 2) begin
            settle_cnt++;
          end else begin
            pending.delete(0);
            settle_cnt = 0;
            gap_cnt    = 0;
          end
        end else begin
          pending.delete(0);
          gap_cnt = 0;
          if (head.kind == STIM_SAMPLE) begin
            nx_start  = 1'b1;
            nx_sample = head.smp;
          end else begin
            nx_cfg_valid = 1'b1;
            nx_index     = head.idx;
            nx_data      = head.data;
          end
        end
      end
    end
    start     <= nx_start;
    cfg_valid <= nx_cfg_valid;
    sample_in <= nx_sample;
    cfg_index <= nx_index;
    cfg_data  <= nx_data;
  end

  always @(posedge clk) begin : monitor
    shaped_t want;
    took_sample = !rst && start && !busy;
    took_write  = !rst && cfg_valid && cfg_ready;
    if (rst) begin
      gain_reg = UNITY_GAIN;
      mode_reg = MODE_HARD;
    end else begin
      if (took_write) begin
        n_writes++;
        case (cfg_index)
          REG_LINEAR_GAIN: gain_reg = cfg_data;
          REG_CURVE_MODE:  mode_reg = cfg_data[MODE_BITS-1:0];
          default: ;
        endcase
      end
      if (took_sample) begin
        shaped_due.push_back(shape_sample(sample_in));
      end
      if (done === 1'b1) begin
        if (shaped_due.size() == 0) begin
          $error("result beat with no sample outstanding: sample_out %0d", sample_out);
          errors++;
        end else begin
          want = shaped_due.pop_front();
          n_checked++;
          if (sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", $signed(want.sample_out), sample_out);
            errors++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            errors++;
          end
        end
      end else if (done !== 1'b0) begin
        $error("done: expected 0 or 1, got %b", done);
        errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("audio_distortion_waveshaper test failed");
      $finish;
    end
  end

endmodule

>>> audio_distortion_waveshaper.f
src/adw_pkg.sv
src/adw_gain.sv
src/adw_shape.sv
src/adw_out.sv
src/audio_distortion_waveshaper.sv
test/tb_top.sv
